### src/vsb_pkg.sv
// Shared constants, types and the arctangent table for the vector slerp blend unit.
// No dependencies; every other file in src imports this package.
package vsb_pkg;

	localparam int ITERATIONS = 16;
	localparam int ATAN_LEN = 24;
	// The CORDIC loops run over at most the length of the arctangent table.
	localparam int CORDIC_STEPS = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;

	localparam int VAL_W = 16;
	localparam int WGT_W = 17;
	localparam int COEF_W = 24;
	localparam int SUM_W = 48;
	localparam int ROOT_W = SUM_W / 2;
	localparam int NUM_W = 64;
	localparam int DIV_W = 72;
	localparam int QB_W = 5;
	localparam int STEP_W = 5;
	localparam int CW = 36;

	localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;
	localparam logic [QB_W-1:0] COS_QBITS = 5'd17;
	localparam logic [QB_W-1:0] COEF_QBITS = 5'd23;

	localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [CW-1:0] Q30_PI = 36'sd3373259426;
	localparam logic signed [CW-1:0] Q30_GAIN = 36'sd652032874;

	// Operation codes of the divide / square root unit.
	localparam logic OP_DIV = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	// Modes of the CORDIC unit.
	localparam logic MODE_VECTOR = 1'b0;
	localparam logic MODE_ROTATE = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
		logic [QB_W-1:0] nbits;
	} ds_cmd_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} ds_stat_t;

	typedef struct packed {
		logic start;
		logic mode;
	} cord_cmd_t;

	// atan(2^-i) in Q2.30 radians.
	function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
		logic signed [CW-1:0] v;
		unique case (i)
			5'd0: v = 36'sd843314857;
			5'd1: v = 36'sd497837830;
			5'd2: v = 36'sd263043837;
			5'd3: v = 36'sd133525159;
			5'd4: v = 36'sd67021687;
			5'd5: v = 36'sd33543516;
			5'd6: v = 36'sd16775851;
			5'd7: v = 36'sd8388437;
			5'd8: v = 36'sd4194283;
			5'd9: v = 36'sd2097149;
			5'd10: v = 36'sd1048576;
			5'd11: v = 36'sd524288;
			5'd12: v = 36'sd262144;
			5'd13: v = 36'sd131072;
			5'd14: v = 36'sd65536;
			5'd15: v = 36'sd32768;
			5'd16: v = 36'sd16384;
			5'd17: v = 36'sd8192;
			5'd18: v = 36'sd4096;
			5'd19: v = 36'sd2048;
			5'd20: v = 36'sd1024;
			5'd21: v = 36'sd512;
			5'd22: v = 36'sd256;
			5'd23: v = 36'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### src/vsb_divsqrt.sv
// Iterative unsigned divider and integer square root, one result bit per cycle.
// Depends on vsb_pkg for widths, operation codes and the command/status structs.
module vsb_divsqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vsb_pkg::ds_cmd_t          cmd,
	input  logic [vsb_pkg::NUM_W-1:0] num,
	input  logic [vsb_pkg::SUM_W-1:0] den,
	output vsb_pkg::ds_stat_t         stat,
	output logic [vsb_pkg::ROOT_W-1:0] res
);
	import vsb_pkg::*;

	logic busy_q, chk_q, op_q, done_q, ovf_q;
	logic [QB_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q, dsh_q, dnext;
	logic [ROOT_W-1:0] quo_q;
	logic [SUM_W-1:0] sqx_q;
	logic [ROOT_W+1:0] sqrem_q, sqcur, sqtrial;
	logic div_ge, ovf_chk, sq_ge;

	always_comb begin
		dnext = dsh_q >> 1;
		div_ge = (rem_q >= dnext);
		ovf_chk = (rem_q >= dsh_q);
		sqcur = {sqrem_q[ROOT_W-1:0], sqx_q[SUM_W-1 -: 2]};
		sqtrial = {quo_q, 2'b01};
		sq_ge = (sqcur >= sqtrial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			op_q <= OP_DIV;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				chk_q <= (cmd.op == OP_DIV);
				ovf_q <= 1'b0;
				cnt_q <= (cmd.op == OP_SQRT) ? QB_W'(ROOT_W) : cmd.nbits;
			end else if (busy_q) begin
				if (op_q == OP_DIV && chk_q) begin
					chk_q <= 1'b0;
					if (ovf_chk) begin
						ovf_q <= 1'b1;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == QB_W'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= DIV_W'(num);
			dsh_q <= DIV_W'(den) << cmd.nbits;
			quo_q <= '0;
			sqx_q <= num[SUM_W-1:0];
			sqrem_q <= '0;
		end else if (busy_q) begin
			if (op_q == OP_SQRT) begin
				sqx_q <= sqx_q << 2;
				if (sq_ge) begin
					sqrem_q <= sqcur - sqtrial;
					quo_q <= {quo_q[ROOT_W-2:0], 1'b1};
				end else begin
					sqrem_q <= sqcur;
					quo_q <= {quo_q[ROOT_W-2:0], 1'b0};
				end
			end else if (!chk_q) begin
				dsh_q <= dnext;
				if (div_ge) begin
					rem_q <= rem_q - dnext;
					quo_q <= {quo_q[ROOT_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.ovf = ovf_q;
	assign res = quo_q;

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("divide/sqrt unit started while busy");
	a_ovf_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && stat.ovf |-> op_q == OP_DIV)
		else $error("overflow flagged on a square root");
`endif

endmodule

### src/vsb_cordic.sv
// Iterative CORDIC unit: vectoring gives the angle, rotation gives the sine.
// Depends on vsb_pkg for the arctangent table, angle constants and the command struct.
module vsb_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vsb_pkg::cord_cmd_t            cmd,
	input  logic signed [vsb_pkg::CW-1:0] x_in,
	input  logic signed [vsb_pkg::CW-1:0] y_in,
	input  logic signed [vsb_pkg::CW-1:0] ang_in,
	output logic                          done,
	output logic signed [vsb_pkg::CW-1:0] z_out,
	output logic signed [vsb_pkg::CW-1:0] y_out
);
	import vsb_pkg::*;

	logic busy_q, done_q, mode_q;
	logic [STEP_W-1:0] step_q;
	logic signed [CW-1:0] x_q, y_q, z_q, xs, ys, at, ang_c, ang_f;
	logic dir_up;

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = atan_q30(step_q);
		// Rotation drives z toward zero, vectoring drives y toward zero.
		dir_up = (mode_q == MODE_ROTATE) ? (z_q >= 0) : !(y_q > 0);
		ang_c = ang_in;
		if (ang_in < 0) ang_c = '0;
		if (ang_in > Q30_PI) ang_c = Q30_PI;
		ang_f = (ang_c > Q30_HALF_PI) ? (Q30_PI - ang_c) : ang_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= MODE_VECTOR;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				mode_q <= cmd.mode;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.mode == MODE_ROTATE) begin
				x_q <= Q30_GAIN;
				y_q <= '0;
				z_q <= ang_f;
			end else if (x_in < 0) begin
				// A vector in the left half plane is first turned by a quarter turn.
				x_q <= y_in;
				y_q <= -x_in;
				z_q <= Q30_HALF_PI;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (dir_up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign z_out = z_q;
	assign y_out = y_q;

`ifndef ASSERT_OFF
	a_cord_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("CORDIC unit started while busy");
`endif

endmodule

### src/vector_slerp_blend_unit.sv
// Accumulate item: the single shared multiplier serves the three products in turn; a new
// transaction is accepted only back in idle. Blend item: result registered.
// The last element of an accumulate pass adds coefficient work (three 24-step square
// roots, three divisions, three 16-step CORDIC runs); less work on fallback.
// Reset clears accumulators, coefficients and linear mode, and loads t = 0 and
// threshold 65503; no clearing pass is needed.
module vector_slerp_blend_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Element stream.
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               command,
	input  logic signed [vsb_pkg::VAL_W-1:0]   first_value,
	input  logic signed [vsb_pkg::VAL_W-1:0]   second_value,
	input  logic                               last_element,
	// Result stream.
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [vsb_pkg::VAL_W-1:0]   blended_value,
	output logic                               linear_used,
	output logic                               last_result,
	// Configuration writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [vsb_pkg::WGT_W-1:0]          cfg_data
);
	import vsb_pkg::*;

	// Configuration register indexes.
	localparam logic [1:0] REG_WEIGHT = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;

	// Sequencer states.
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_ACC_AA   = 5'd1;
	localparam logic [4:0] S_ACC_BB   = 5'd2;
	localparam logic [4:0] S_ACC_AB   = 5'd3;
	localparam logic [4:0] S_ACC_END  = 5'd4;
	localparam logic [4:0] S_BL_A     = 5'd5;
	localparam logic [4:0] S_BL_B     = 5'd6;
	localparam logic [4:0] S_BL_SUM   = 5'd7;
	localparam logic [4:0] S_SQ0      = 5'd8;
	localparam logic [4:0] S_SQ0_W    = 5'd9;
	localparam logic [4:0] S_SQ1      = 5'd10;
	localparam logic [4:0] S_SQ1_W    = 5'd11;
	localparam logic [4:0] S_NN       = 5'd12;
	localparam logic [4:0] S_DIV_COS  = 5'd13;
	localparam logic [4:0] S_DIV_COS_W = 5'd14;
	localparam logic [4:0] S_MAG2     = 5'd15;
	localparam logic [4:0] S_SQS      = 5'd16;
	localparam logic [4:0] S_SQS_W    = 5'd17;
	localparam logic [4:0] S_VEC      = 5'd18;
	localparam logic [4:0] S_VEC_W    = 5'd19;
	localparam logic [4:0] S_THT      = 5'd20;
	localparam logic [4:0] S_ROT0     = 5'd21;
	localparam logic [4:0] S_ROT0_W   = 5'd22;
	localparam logic [4:0] S_DIV0     = 5'd23;
	localparam logic [4:0] S_DIV0_W   = 5'd24;
	localparam logic [4:0] S_ROT1     = 5'd25;
	localparam logic [4:0] S_ROT1_W   = 5'd26;
	localparam logic [4:0] S_DIV1     = 5'd27;
	localparam logic [4:0] S_DIV1_W   = 5'd28;
	localparam logic [4:0] S_FIN      = 5'd29;

	logic [4:0] state_q;

	// Configuration.
	logic [WGT_W-1:0] weight_q, thr_q, wgt;

	// Latched element.
	logic signed [VAL_W-1:0] a_q, b_q;
	logic last_q;

	// Accumulators and coefficients.
	logic [SUM_W-1:0] sum0_q, sum1_q;
	logic signed [SUM_W-1:0] cross_q;
	logic signed [COEF_W-1:0] coef0_q, coef1_q;
	logic lin_mode_q;

	// Coefficient working registers.
	logic [ROOT_W-1:0] n0_q, n1_q;
	logic lin_q;
	logic [WGT_W-1:0] mag_q, s_q, mag_w;
	logic signed [CW-1:0] theta0_q, thetat_q, sin_q, thetat_w, abs_sin;
	logic sneg_q;
	logic [SUM_W-1:0] abs_cross;

	// Shared multiplier.
	logic signed [CW-1:0] mul_a;
	logic signed [COEF_W:0] mul_b;
	logic signed [CW+COEF_W:0] mul_p, p_q;

	// Blend datapath.
	logic signed [40:0] acc_q;
	logic signed [41:0] tot;
	logic signed [25:0] rnd;
	logic signed [VAL_W-1:0] blend_w;

	// Result register.
	logic rv_q;
	logic signed [VAL_W-1:0] res_val_q;
	logic res_lin_q, res_last_q;

	// Accumulator sums.
	logic [SUM_W:0] s0_sum, s1_sum;
	logic signed [SUM_W:0] cr_sum;

	// Shared iterative units.
	ds_cmd_t ds_cmd;
	ds_stat_t ds_stat;
	logic [NUM_W-1:0] ds_num;
	logic [SUM_W-1:0] ds_den;
	logic [ROOT_W-1:0] ds_res;
	cord_cmd_t cd_cmd;
	logic cd_done;
	logic signed [CW-1:0] cd_x, cd_y, cd_ang, cd_z, cd_yo, cmag;

	logic accept, out_free;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free = !rv_q || !result_stall;
	assign cfg_ready = 1'b1;
	assign wgt = (weight_q > WGT_ONE) ? WGT_ONE : weight_q;

	// Signed quotient from magnitude division, saturated to the coefficient range.
	function automatic logic signed [COEF_W-1:0] coef_of(input logic ovf,
			input logic [ROOT_W-1:0] q, input logic neg);
		logic signed [COEF_W-1:0] v;
		if (ovf) v = neg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		else if (neg) v = -COEF_W'(q[COEF_W-2:0]);
		else v = COEF_W'(q[COEF_W-2:0]);
		return v;
	endfunction

	// Multiplier operand selection by sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ACC_AA: begin mul_a = CW'(a_q); mul_b = (COEF_W+1)'(a_q); end
			S_ACC_BB: begin mul_a = CW'(b_q); mul_b = (COEF_W+1)'(b_q); end
			S_ACC_AB: begin mul_a = CW'(a_q); mul_b = (COEF_W+1)'(b_q); end
			S_BL_A:   begin mul_a = CW'(a_q); mul_b = (COEF_W+1)'(coef0_q); end
			S_BL_B:   begin mul_a = CW'(b_q); mul_b = (COEF_W+1)'(coef1_q); end
			// The second product is held while the result register is busy.
			S_BL_SUM: begin mul_a = CW'(b_q); mul_b = (COEF_W+1)'(coef1_q); end
			S_NN:     begin mul_a = CW'(n0_q); mul_b = (COEF_W+1)'(n1_q); end
			S_MAG2:   begin mul_a = CW'(mag_q); mul_b = (COEF_W+1)'(mag_q); end
			S_THT:    begin mul_a = theta0_q; mul_b = (COEF_W+1)'(wgt); end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		s0_sum = (SUM_W+1)'(sum0_q) + (SUM_W+1)'(p_q[31:0]);
		s1_sum = (SUM_W+1)'(sum1_q) + (SUM_W+1)'(p_q[31:0]);
		cr_sum = (SUM_W+1)'(cross_q) + (SUM_W+1)'(p_q);
		abs_cross = cross_q[SUM_W-1] ? SUM_W'(-cross_q) : SUM_W'(cross_q);
		thetat_w = p_q[51:16];
		abs_sin = sin_q[CW-1] ? -sin_q : sin_q;
		if (ds_stat.ovf || ds_res[WGT_W-1:0] > WGT_ONE) mag_w = WGT_ONE;
		else mag_w = ds_res[WGT_W-1:0];
		// Blend: round half up toward floor, then saturate to Q4.12.
		tot = 42'(acc_q) + 42'(p_q) + 42'sd32768;
		rnd = tot[41:16];
		if (rnd > 26'sd32767) blend_w = 16'sh7fff;
		else if (rnd < -26'sd32768) blend_w = 16'sh8000;
		else blend_w = rnd[VAL_W-1:0];
	end

	// Commands to the shared divide / square root and CORDIC units.
	always_comb begin
		ds_cmd = '0;
		ds_num = '0;
		ds_den = '0;
		cd_cmd = '0;
		cmag = CW'(mag_q) << 14;
		cd_x = lin_q ? -cmag : cmag;
		cd_y = CW'(s_q) << 14;
		cd_ang = '0;
		case (state_q)
			S_SQ0: begin
				ds_cmd = '{start: 1'b1, op: OP_SQRT, nbits: '0};
				ds_num = NUM_W'(sum0_q);
			end
			S_SQ1: begin
				ds_cmd = '{start: 1'b1, op: OP_SQRT, nbits: '0};
				ds_num = NUM_W'(sum1_q);
			end
			S_DIV_COS: begin
				ds_cmd = '{start: 1'b1, op: OP_DIV, nbits: COS_QBITS};
				ds_num = {abs_cross, 16'd0};
				ds_den = p_q[SUM_W-1:0];
			end
			S_SQS: begin
				ds_cmd = '{start: 1'b1, op: OP_SQRT, nbits: '0};
				ds_num = NUM_W'(33'h1_0000_0000 - p_q[32:0]);
			end
			S_DIV0, S_DIV1: begin
				ds_cmd = '{start: 1'b1, op: OP_DIV, nbits: COEF_QBITS};
				ds_num = NUM_W'(abs_sin) << 2;
				ds_den = SUM_W'(s_q);
			end
			S_VEC: cd_cmd = '{start: 1'b1, mode: MODE_VECTOR};
			S_ROT0: begin
				cd_cmd = '{start: 1'b1, mode: MODE_ROTATE};
				cd_ang = theta0_q - thetat_w;
			end
			S_ROT1: begin
				cd_cmd = '{start: 1'b1, mode: MODE_ROTATE};
				cd_ang = thetat_q;
			end
			default: begin
				ds_cmd = '0;
				cd_cmd = '0;
			end
		endcase
		// The cosine sign rides on the cross sum sign, held until the sums clear.
		if (state_q == S_VEC) cd_x = cross_q[SUM_W-1] ? -cmag : cmag;
	end

	vsb_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ds_cmd),
		.num    (ds_num),
		.den    (ds_den),
		.stat   (ds_stat),
		.res    (ds_res)
	);

	vsb_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cd_cmd),
		.x_in   (cd_x),
		.y_in   (cd_y),
		.ang_in (cd_ang),
		.done   (cd_done),
		.z_out  (cd_z),
		.y_out  (cd_yo)
	);

	// Sequencer, accumulators, coefficients and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			weight_q <= '0;
			thr_q <= 17'd65503;
			sum0_q <= '0;
			sum1_q <= '0;
			cross_q <= '0;
			coef0_q <= '0;
			coef1_q <= '0;
			lin_mode_q <= 1'b0;
			lin_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WEIGHT: weight_q <= cfg_data;
					REG_THRESH: thr_q <= cfg_data;
					default: ;
				endcase
			end
			// A new result loads as the previous one leaves, or into an empty register.
			if (state_q == S_BL_SUM && out_free) rv_q <= 1'b1;
			else if (!result_stall) rv_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (accept) state_q <= command ? S_BL_A : S_ACC_AA;
				S_ACC_AA: state_q <= S_ACC_BB;
				S_ACC_BB: begin
					sum0_q <= s0_sum[SUM_W] ? {SUM_W{1'b1}} : s0_sum[SUM_W-1:0];
					state_q <= S_ACC_AB;
				end
				S_ACC_AB: begin
					sum1_q <= s1_sum[SUM_W] ? {SUM_W{1'b1}} : s1_sum[SUM_W-1:0];
					state_q <= S_ACC_END;
				end
				S_ACC_END: begin
					if (cr_sum[SUM_W] != cr_sum[SUM_W-1])
						cross_q <= cr_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
						                         : {1'b0, {(SUM_W-1){1'b1}}};
					else
						cross_q <= cr_sum[SUM_W-1:0];
					lin_q <= 1'b0;
					state_q <= last_q ? S_SQ0 : S_IDLE;
				end
				S_BL_A: state_q <= S_BL_B;
				S_BL_B: state_q <= S_BL_SUM;
				S_BL_SUM: if (out_free) state_q <= S_IDLE;
				S_SQ0: state_q <= S_SQ0_W;
				S_SQ0_W: if (ds_stat.done) state_q <= S_SQ1;
				S_SQ1: state_q <= S_SQ1_W;
				S_SQ1_W: if (ds_stat.done) state_q <= S_NN;
				S_NN: begin
					// A zero norm means an empty or all-zero vector.
					if (n0_q == '0 || n1_q == '0) begin
						lin_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV_COS;
					end
				end
				S_DIV_COS: state_q <= S_DIV_COS_W;
				S_DIV_COS_W: if (ds_stat.done) begin
					if (mag_w > thr_q) begin
						lin_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MAG2;
					end
				end
				S_MAG2: state_q <= S_SQS;
				S_SQS: state_q <= S_SQS_W;
				S_SQS_W: if (ds_stat.done) begin
					// Zero sine: parallel or anti-parallel vectors.
					if (ds_res == '0) begin
						lin_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_VEC;
					end
				end
				S_VEC: state_q <= S_VEC_W;
				S_VEC_W: if (cd_done) state_q <= S_THT;
				S_THT: state_q <= S_ROT0;
				S_ROT0: state_q <= S_ROT0_W;
				S_ROT0_W: if (cd_done) state_q <= S_DIV0;
				S_DIV0: state_q <= S_DIV0_W;
				S_DIV0_W: if (ds_stat.done) begin
					coef0_q <= coef_of(ds_stat.ovf, ds_res, sneg_q);
					state_q <= S_ROT1;
				end
				S_ROT1: state_q <= S_ROT1_W;
				S_ROT1_W: if (cd_done) state_q <= S_DIV1;
				S_DIV1: state_q <= S_DIV1_W;
				S_DIV1_W: if (ds_stat.done) begin
					coef1_q <= coef_of(ds_stat.ovf, ds_res, sneg_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (lin_q) begin
						coef0_q <= COEF_W'(WGT_ONE - wgt);
						coef1_q <= COEF_W'(wgt);
					end
					lin_mode_q <= lin_q;
					sum0_q <= '0;
					sum1_q <= '0;
					cross_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		p_q <= mul_p;
		if (accept) begin
			a_q <= first_value;
			b_q <= second_value;
			last_q <= last_element;
		end
		if (state_q == S_BL_B) acc_q <= p_q[40:0];
		if (state_q == S_BL_SUM && out_free) begin
			res_val_q <= blend_w;
			res_lin_q <= lin_mode_q;
			res_last_q <= last_q;
		end
		if (state_q == S_SQ0_W && ds_stat.done) n0_q <= ds_res;
		if (state_q == S_SQ1_W && ds_stat.done) n1_q <= ds_res;
		if (state_q == S_DIV_COS_W && ds_stat.done) mag_q <= mag_w;
		if (state_q == S_SQS_W && ds_stat.done) s_q <= ds_res[WGT_W-1:0];
		if (state_q == S_VEC_W && cd_done) theta0_q <= cd_z;
		if (state_q == S_ROT0) thetat_q <= thetat_w;
		if ((state_q == S_ROT0_W || state_q == S_ROT1_W) && cd_done) sin_q <= cd_yo;
		if (state_q == S_DIV0 || state_q == S_DIV1) sneg_q <= sin_q[CW-1];
	end

	assign result_valid = rv_q;
	assign blended_value = res_val_q;
	assign linear_used = res_lin_q;
	assign last_result = res_last_q;

`ifndef ASSERT_OFF
	a_result_from_blend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_BL_SUM)
		else $error("result transaction raised outside the blend step");
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> sum0_q == '0 && sum1_q == '0 && cross_q == '0)
		else $error("accumulators not cleared after coefficient update");
	a_linear_weights: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && lin_q |=>
			(25'(coef0_q) + 25'(coef1_q)) == 25'd65536)
		else $error("linear fallback weights do not sum to one");
`endif

endmodule

### test/tb_vector_slerp_blend_unit.sv
// Self-checking testbench for vector_slerp_blend_unit: directed table, then random vector pairs.
// Depends on src/vsb_pkg.sv and src/vector_slerp_blend_unit.sv; reads no files.
`timescale 1ns / 1ps

module tb_vector_slerp_blend_unit;
	import vsb_pkg::*;

	// Command codes on the element stream.
	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_BLEND = 1'b1;
	// Configuration register indexes.
	localparam logic [1:0] REG_INTERP_WEIGHT = 2'd0;
	localparam logic [1:0] REG_COS_THRESHOLD = 2'd1;

	localparam longint unsigned SQUARE_SUM_MAX = (64'd1 << 48) - 1;
	localparam longint CROSS_SUM_MAX = (64'sd1 <<< 47) - 1;
	localparam longint CROSS_SUM_MIN = -(64'sd1 <<< 47);
	localparam int ITEM_TARGET = 1100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic command = CMD_ACCUMULATE;
	logic signed [VAL_W-1:0] first_value = '0;
	logic signed [VAL_W-1:0] second_value = '0;
	logic last_element = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [VAL_W-1:0] blended_value;
	logic linear_used;
	logic last_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [WGT_W-1:0] cfg_data = '0;

	// Optional typed-in expectation travelling alongside the current transaction.
	logic typed_row = 1'b0;
	logic signed [VAL_W-1:0] typed_value = '0;
	logic typed_linear = 1'b0;

	vector_slerp_blend_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic linear;
		logic last;
	} blend_result_t;

	// Shadow of the block's configuration and accumulated state.
	logic [WGT_W-1:0] model_weight;
	logic [WGT_W-1:0] model_threshold;
	longint unsigned first_energy, second_energy;
	longint cross_energy;
	longint weight_first, weight_second;
	logic model_linear;

	blend_result_t pending_blends[$];
	int errors = 0;
	bit quiet = 0;      // no idling on either side near the end
	bit long_hold = 0;  // receiver holds off for a long stretch

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// CORDIC vectoring: angle of (x, y) in Q2.30 radians.
	function automatic longint vector_angle(input longint x, input longint y);
		longint z, nx, ny, tmp;
		z = 0;
		if (x < 0) begin
			tmp = x;
			x = y;
			y = -tmp;
			z = Q30_HALF_PI;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += longint'(atan_q30(i[STEP_W-1:0]));
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= longint'(atan_q30(i[STEP_W-1:0]));
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	// CORDIC rotation: sine of a Q2.30 angle, in Q30, with the gain folded into x.
	function automatic longint rotated_sine(input longint a);
		longint x, y, nx, ny;
		x = Q30_GAIN;
		y = 0;
		if (a < 0) a = 0;
		if (a > Q30_PI) a = Q30_PI;
		if (a > Q30_HALF_PI) a = Q30_PI - a;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				a -= longint'(atan_q30(i[STEP_W-1:0]));
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				a += longint'(atan_q30(i[STEP_W-1:0]));
			end
			x = nx;
			y = ny;
		end
		return y;
	endfunction

	function automatic longint clip_coefficient(input longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// Fix the two blend weights at the end of an accumulate pass.
	function automatic void settle_weights();
		longint t, cosv, theta0, theta_t;
		longint unsigned n0, n1, mag, sinv;
		bit lin;
		lin = 0;
		t = (model_weight > WGT_ONE) ? 65536 : longint'(model_weight);
		n0 = int_sqrt(first_energy);
		n1 = int_sqrt(second_energy);
		if (n0 == 0 || n1 == 0) begin
			lin = 1;
		end else begin
			mag = (cross_energy < 0) ? longint'(-cross_energy) : cross_energy;
			mag = (mag << 16) / (n0 * n1);
			if (mag > 65536) mag = 65536;
			if (mag > model_threshold) lin = 1;
			cosv = (cross_energy < 0) ? -longint'(mag) : longint'(mag);
			sinv = int_sqrt((64'd1 << 32) - mag * mag);
			if (sinv == 0) lin = 1;
			if (!lin) begin
				theta0 = vector_angle(cosv * 16384, longint'(sinv) * 16384);
				theta_t = (theta0 * t) >>> 16;
				weight_first = clip_coefficient((rotated_sine(theta0 - theta_t) * 4)
					/ longint'(sinv));
				weight_second = clip_coefficient((rotated_sine(theta_t) * 4) / longint'(sinv));
			end
		end
		if (lin) begin
			weight_first = 65536 - t;
			weight_second = t;
		end
		model_linear = lin;
	endfunction

	// Advance the shadow state by one element; returns 1 when a result is due.
	function automatic bit blend_step(input logic cmd, input logic signed [VAL_W-1:0] a16,
			input logic signed [VAL_W-1:0] b16, input logic last, output blend_result_t res);
		longint a, b, acc, r;
		longint unsigned p;
		a = a16;
		b = b16;
		res = '0;
		if (cmd == CMD_ACCUMULATE) begin
			p = a * a;
			first_energy = (first_energy > SQUARE_SUM_MAX - p) ? SQUARE_SUM_MAX : first_energy + p;
			p = b * b;
			second_energy = (second_energy > SQUARE_SUM_MAX - p) ? SQUARE_SUM_MAX
				: second_energy + p;
			cross_energy += a * b;
			if (cross_energy > CROSS_SUM_MAX) cross_energy = CROSS_SUM_MAX;
			if (cross_energy < CROSS_SUM_MIN) cross_energy = CROSS_SUM_MIN;
			if (last) begin
				settle_weights();
				first_energy = 0;
				second_energy = 0;
				cross_energy = 0;
			end
			return 0;
		end
		acc = weight_first * a + weight_second * b;
		r = (acc + 32768) >>> 16;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		res.value = r[VAL_W-1:0];
		res.linear = model_linear;
		res.last = last;
		return 1;
	endfunction

	// Input side: predict at every accepted transaction.
	always @(posedge clk) begin
		blend_result_t res;
		if (item_valid && !item_stall) begin
			if (blend_step(command, first_value, second_value, last_element, res)) begin
				if (typed_row && (res.value !== typed_value || res.linear !== typed_linear)) begin
					errors++;
					$display("%0t: table row disagrees, typed %0d/%0b predicted %0d/%0b",
						$time, typed_value, typed_linear, res.value, res.linear);
				end
				pending_blends = {pending_blends, res};
			end
		end
	end

	// Output side: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		blend_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_blends.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d/%0b/%0b",
					$time, blended_value, linear_used, last_result);
			end else begin
				exp_r = pending_blends.pop_front();
				if (blended_value !== exp_r.value) begin
					errors++;
					$display("%0t: blended_value expected %0d actual %0d",
						$time, exp_r.value, blended_value);
				end
				if (linear_used !== exp_r.linear) begin
					errors++;
					$display("%0t: linear_used expected %0b actual %0b",
						$time, exp_r.linear, linear_used);
				end
				if (last_result !== exp_r.last) begin
					errors++;
					$display("%0t: last_result expected %0b actual %0b",
						$time, exp_r.last, last_result);
				end
			end
		end
	end

	// Receiver: random stall bursts, a single requested long hold, none in the quiet tail.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (quiet) begin
				result_stall <= 1'b0;
			end else if (long_hold) begin
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				result_stall <= 1'b0;
				long_hold = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	int sent = 0;

	// One transaction on the element stream, with an optional idle burst first.
	task automatic send_element(input logic cmd, input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic last,
			input bit typed = 0, input logic signed [VAL_W-1:0] tv = '0, input logic tl = 1'b0);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		first_value <= a;
		second_value <= b;
		last_element <= last;
		typed_row <= typed;
		typed_value <= tv;
		typed_linear <= tl;
		do @(negedge clk); while (item_stall);
		@(posedge clk);
		sent++;
	endtask

	// Register write while the block is idle; the coefficient work produces no result, so
	// a fixed pause covers it after the last expected result has arrived.
	task automatic write_register(input logic [1:0] idx, input logic [WGT_W-1:0] data);
		item_valid <= 1'b0;
		wait (pending_blends.size() == 0);
		repeat (400) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_INTERP_WEIGHT) model_weight = data;
		else if (idx == REG_COS_THRESHOLD) model_threshold = data;
	endtask

	typedef struct {
		logic cmd;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
		logic last;
		bit typed;
		logic signed [VAL_W-1:0] tv;
		logic tl;
	} stim_row_t;

	// Directed rows. Typed results: before any coefficients the output is zero; with t = 0
	// and linear fallback the output is the first element itself.
	stim_row_t directed[] = '{
		'{CMD_BLEND, 16'sh7fff, 16'sh8000, 1'b0, 1, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sh8000, 16'sh7fff, 1'b1, 1, 16'sd0, 1'b0},
		// Empty (all-zero) vector forces the linear fallback.
		'{CMD_ACCUMULATE, 16'sd0, 16'sd0, 1'b1, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sh7fff, 16'sh8000, 1'b0, 1, 16'sh7fff, 1'b1},
		'{CMD_BLEND, 16'sh8000, 16'sh7fff, 1'b1, 1, 16'sh8000, 1'b1},
		// Orthogonal unit vectors: true spherical blend.
		'{CMD_ACCUMULATE, 16'sd4096, 16'sd0, 1'b0, 0, 16'sd0, 1'b0},
		'{CMD_ACCUMULATE, 16'sd0, 16'sd4096, 1'b1, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sd4096, 16'sd0, 1'b0, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sd0, 16'sd4096, 1'b1, 0, 16'sd0, 1'b0},
		// One norm zero.
		'{CMD_ACCUMULATE, 16'sh7fff, 16'sd0, 1'b1, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sh7fff, 16'sh7fff, 1'b1, 1, 16'sh7fff, 1'b1},
		// Parallel and anti-parallel extremes: cosine saturates, sine is zero.
		'{CMD_ACCUMULATE, 16'sh8000, 16'sh8000, 1'b1, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sh8000, 16'sh7fff, 1'b1, 1, 16'sh8000, 1'b1},
		'{CMD_ACCUMULATE, 16'sh7fff, 16'sh8001, 1'b1, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sh7fff, 16'sd0, 1'b1, 1, 16'sh7fff, 1'b1},
		// Obtuse angle: negative cosine takes the quarter-turn path.
		'{CMD_ACCUMULATE, 16'sd4096, 16'sh8000, 1'b0, 0, 16'sd0, 1'b0},
		'{CMD_ACCUMULATE, 16'sd1000, 16'sd3000, 1'b1, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sd4096, 16'sh8000, 1'b0, 0, 16'sd0, 1'b0},
		'{CMD_BLEND, 16'sd1000, 16'sd3000, 1'b1, 0, 16'sd0, 1'b0}
	};

	logic signed [VAL_W-1:0] vec_a[64], vec_b[64];

	function automatic logic signed [VAL_W-1:0] pick_value(input int style);
		case (style)
			0: return VAL_W'($urandom());
			1: return VAL_W'($urandom_range(0, 8192) - 4096);
			default: return VAL_W'($urandom_range(0, 64) - 32);
		endcase
	endfunction

	// A well-formed slerp: accumulate pass over a random pair of vectors, then blend pass.
	task automatic run_vector_pair();
		int len, style, shape;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 8);
		style = $urandom_range(0, 2);
		shape = $urandom_range(0, 5);
		for (int i = 0; i < len; i++) begin
			vec_a[i] = pick_value(style);
			case (shape)
				0: vec_b[i] = vec_a[i];
				1: vec_b[i] = -vec_a[i];
				2: vec_b[i] = vec_a[i] + $signed(4'($urandom()));
				3: vec_b[i] = 16'sd0;
				default: vec_b[i] = pick_value(style);
			endcase
		end
		for (int i = 0; i < len; i++)
			send_element(CMD_ACCUMULATE, vec_a[i], vec_b[i], i == len - 1);
		for (int i = 0; i < len; i++)
			send_element(CMD_BLEND, vec_a[i], vec_b[i], i == len - 1);
	endtask

	task automatic random_config();
		logic [WGT_W-1:0] tw, th;
		case ($urandom_range(0, 5))
			0: tw = 17'd0;
			1: tw = WGT_ONE;
			2: tw = 17'h1ffff;
			default: tw = WGT_W'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 5))
			0: th = 17'd0;
			1: th = WGT_ONE;
			2: th = 17'd65503;
			3: th = WGT_W'($urandom());
			default: th = WGT_W'($urandom_range(60000, 65536));
		endcase
		write_register(REG_INTERP_WEIGHT, tw);
		write_register(REG_COS_THRESHOLD, th);
	endtask

	initial begin
		model_weight = '0;
		model_threshold = 17'd65503;
		first_energy = 0;
		second_energy = 0;
		cross_energy = 0;
		weight_first = 0;
		weight_second = 0;
		model_linear = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_element(directed[i].cmd, directed[i].a, directed[i].b, directed[i].last,
				directed[i].typed, directed[i].tv, directed[i].tl);
		write_register(REG_INTERP_WEIGHT, 17'd32768);
		run_vector_pair();

		// Long receiver hold while blend transactions keep coming, so the block backs up.
		long_hold = 1;
		for (int i = 0; i < 40; i++)
			send_element(CMD_BLEND, VAL_W'($urandom()), VAL_W'($urandom()), i == 39);

		// Sender pauses until every expected result is in.
		item_valid <= 1'b0;
		wait (pending_blends.size() == 0);
		@(posedge clk);

		while (sent < ITEM_TARGET) begin
			if (sent > ITEM_TARGET * 85 / 100) quiet = 1;
			if (!quiet && $urandom_range(0, 11) == 0) random_config();
			if ($urandom_range(0, 9) == 0) begin
				// Noise: stray elements of either kind, or a blend pass with no fresh weights.
				repeat ($urandom_range(1, 4))
					send_element(1'($urandom()), VAL_W'($urandom()), VAL_W'($urandom()),
						1'($urandom()));
			end else begin
				run_vector_pair();
			end
		end

		item_valid <= 1'b0;
		wait (pending_blends.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_blends.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
src/vsb_pkg.sv
src/vsb_divsqrt.sv
src/vsb_cordic.sv
src/vector_slerp_blend_unit.sv
test/tb_vector_slerp_blend_unit.sv
